/* rtl/core/tpws_pkg.sv */
// Shared types, widths and constants of the term proximity window scorer.
// No dependencies; compile first.
package tpws_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = PTR_W + 1;
    localparam int MAX_TERMS    = 16;
    localparam int TERM_W       = 4;
    localparam int COUNT_W      = FILL_W;
    localparam int DISTINCT_W   = $clog2(MAX_TERMS) + 1;
    localparam int MAX_WINDOW   = 10;
    localparam int WS_W         = 4;
    localparam int POS_W        = 16;
    localparam int RANK_W       = 40;
    localparam int BONUS_W      = 18;
    localparam int PARTIAL_W    = 16;
    localparam int FULL_BONUS   = 256000;
    localparam int WS_RESET     = 1;

    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = PADDR_W - 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = '0;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [TERM_W-1:0] term;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIT,
        ST_OVF,
        ST_ADD,
        ST_FINAL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic score;
        logic clear;
        logic set_ovf;
    } rank_ctl_t;

    typedef logic [PARTIAL_W-1:0] partial_t;

    // floor(51200 * distinct / size), Q.8; row = size, column = distinct (< size)
    localparam partial_t PARTIAL_TBL [MAX_WINDOW+1][MAX_WINDOW] = '{
        '{0, 0,     0,     0,     0,     0,     0,     0,     0,     0},
        '{0, 0,     0,     0,     0,     0,     0,     0,     0,     0},
        '{0, 25600, 0,     0,     0,     0,     0,     0,     0,     0},
        '{0, 17066, 34133, 0,     0,     0,     0,     0,     0,     0},
        '{0, 12800, 25600, 38400, 0,     0,     0,     0,     0,     0},
        '{0, 10240, 20480, 30720, 40960, 0,     0,     0,     0,     0},
        '{0, 8533,  17066, 25600, 34133, 42666, 0,     0,     0,     0},
        '{0, 7314,  14628, 21942, 29257, 36571, 43885, 0,     0,     0},
        '{0, 6400,  12800, 19200, 25600, 32000, 38400, 44800, 0,     0},
        '{0, 5688,  11377, 17066, 22755, 28444, 34133, 39822, 45511, 0},
        '{0, 5120,  10240, 15360, 20480, 25600, 30720, 35840, 40960, 46080}
    };

    function automatic logic [BONUS_W-1:0] window_bonus(
        input logic [WS_W-1:0]       eff,
        input logic [DISTINCT_W-1:0] distinct
    );
        logic [BONUS_W-1:0] b;
        if (distinct >= DISTINCT_W'(eff))
        begin
            b = BONUS_W'(FULL_BONUS);
        end
        else
        begin
            b = BONUS_W'(PARTIAL_TBL[eff][distinct[WS_W-1:0]]);
        end
        return b;
    endfunction

endpackage

/* rtl/core/tpws_if.sv */
// Valid/ready channel interfaces: hit words in, rank words out.
// Depends on tpws_pkg.
interface tpws_hit_if;
    logic                         valid;
    logic                         ready;
    logic [tpws_pkg::POS_W-1:0]   position;
    logic [tpws_pkg::TERM_W-1:0]  term_index;
    logic                         present;
    logic                         last;

    modport source (output valid, position, term_index, present, last, input ready);
    modport sink   (input valid, position, term_index, present, last, output ready);
endinterface

interface tpws_res_if;
    logic                         valid;
    logic                         ready;
    logic [tpws_pkg::RANK_W-1:0]  rank;
    logic                         overflow;

    modport source (output valid, rank, overflow, input ready);
    modport sink   (input valid, rank, overflow, output ready);
endinterface

/* rtl/core/tpws_ram.sv */
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module tpws_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 20,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/tpws_cfg.sv */
// APB-style configuration port holding the window size register.
// Depends on tpws_pkg.
module tpws_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpws_pkg::PADDR_W-1:0]  paddr,
    input  logic [tpws_pkg::PDATA_W-1:0]  pwdata,
    output logic [tpws_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [tpws_pkg::WS_W-1:0]     eff_size
);
    import tpws_pkg::*;

    logic [WS_W-1:0]      ws_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_WINDOW_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= WS_W'(WS_RESET);
        end
        else if (wr_en)
        begin
            ws_reg <= pwdata[WS_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_WINDOW_SIZE)
        begin
            prdata = PDATA_W'(ws_reg);
        end
    end

    // zero behaves as one, large values clamp
    always_comb
    begin
        if (ws_reg == '0)
        begin
            eff_size = WS_W'(1);
        end
        else if (ws_reg > WS_W'(MAX_WINDOW))
        begin
            eff_size = WS_W'(MAX_WINDOW);
        end
        else
        begin
            eff_size = ws_reg;
        end
    end

endmodule

/* rtl/core/tpws_rank.sv */
// Rank accumulator: window bonus lookup, saturating add, overflow flag.
// Depends on tpws_pkg.
module tpws_rank (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tpws_pkg::rank_ctl_t             ctl,
    input  logic [tpws_pkg::WS_W-1:0]       eff_size,
    input  logic [tpws_pkg::DISTINCT_W-1:0] distinct,
    output logic [tpws_pkg::RANK_W-1:0]     rank,
    output logic                            overflow
);
    import tpws_pkg::*;

    logic [RANK_W-1:0]  rank_reg, rank_next;
    logic               ovf_reg, ovf_next;
    logic [BONUS_W-1:0] bonus;
    logic [RANK_W:0]    sum;

    assign bonus = window_bonus(eff_size, distinct);
    assign sum   = {1'b0, rank_reg} + (RANK_W + 1)'(bonus);

    always_comb
    begin
        rank_next = rank_reg;
        ovf_next  = ovf_reg;
        if (ctl.clear)
        begin
            rank_next = '0;
            ovf_next  = 1'b0;
        end
        else
        begin
            if (ctl.score)
            begin
                if (sum[RANK_W])
                begin
                    rank_next = '1;
                    ovf_next  = 1'b1;
                end
                else
                begin
                    rank_next = sum[RANK_W-1:0];
                end
            end
            if (ctl.set_ovf)
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            rank_reg <= rank_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign rank     = rank_reg;
    assign overflow = ovf_reg;

endmodule

/* rtl/core/term_proximity_window_scorer_core.sv */
// Term proximity window scorer, top level: sequencer, window ring RAM, term counts.
// Sequence: a hit that fits is accepted, fit-checked and stored; each hit
// dropped from the window adds a fit-check pass, a store overflow adds an overflow drop.
// A last word adds a final score and a result load; the result sits in an output register.
// One word in flight at a time; the fit/drop loop on the ring RAM read sets the rate.
// Reset (async, rst_n low): empty window, zero counts/rank, window size 1; RAM uncleared.
module term_proximity_window_scorer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpws_pkg::PADDR_W-1:0]  paddr,
    input  logic [tpws_pkg::PDATA_W-1:0]  pwdata,
    output logic [tpws_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    tpws_hit_if.sink                      hits,
    tpws_res_if.source                    result
);
    import tpws_pkg::*;

    // Sequencer state and window bookkeeping
    state_t                state_reg, state_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [DISTINCT_W-1:0] distinct_reg, distinct_next;
    logic                  scored_reg, scored_next;     // first drop of this word scored
    logic                  load_pend_reg, load_pend_next; // RAM read data is the new head

    // Cached copy of the oldest entry, refreshed from the RAM after each drop
    entry_t                cache_reg, cache_next;
    entry_t                head_ent;

    // Word being worked on
    logic [POS_W-1:0]      pos_reg;
    logic [TERM_W-1:0]     term_reg;
    logic                  present_reg;
    logic                  last_reg;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    logic [RANK_W-1:0]     out_rank_reg, out_rank_next;
    logic                  out_ovf_reg, out_ovf_next;

    // Term count registers: one read/modify/write a cycle
    logic [COUNT_W-1:0]    counts_reg [MAX_TERMS];
    logic [TERM_W-1:0]     cnt_idx;
    logic [COUNT_W-1:0]    cnt_rd;
    logic [COUNT_W-1:0]    cnt_wval;
    logic                  cnt_we;
    logic                  cnt_clr;

    // Ring RAM ports
    logic                  ram_we, ram_re;
    logic [PTR_W-1:0]      ram_waddr, ram_raddr;
    entry_t                ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;

    logic [WS_W-1:0]       eff_size;
    rank_ctl_t             rctl;
    logic [RANK_W-1:0]     rank;
    logic                  rank_ovf;

    logic                  fits;
    logic [POS_W-1:0]      span;
    logic                  full;
    logic                  accept;

    tpws_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .eff_size (eff_size)
    );

    tpws_ram #(
        .DEPTH (WINDOW_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tpws_rank u_rank (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rctl),
        .eff_size (eff_size),
        .distinct (distinct_reg),
        .rank     (rank),
        .overflow (rank_ovf)
    );

    // Forward the fresh RAM read in the cycle after a drop
    assign head_ent = load_pend_reg ? entry_t'(ram_rdata) : cache_reg;

    // Fits if empty, or newest not below oldest and span under the window size
    assign span = pos_reg - head_ent.pos;
    assign fits = (fill_reg == '0) ||
                  ((pos_reg >= head_ent.pos) && (span < POS_W'(eff_size)));
    assign full = (fill_reg == FILL_W'(WINDOW_DEPTH));

    assign hits.ready = (state_reg == ST_IDLE);
    assign accept     = hits.valid && hits.ready;
    assign cnt_rd     = counts_reg[cnt_idx];

    assign result.valid    = out_valid_reg;
    assign result.rank     = out_rank_reg;
    assign result.overflow = out_ovf_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        distinct_next  = distinct_reg;
        scored_next    = scored_reg;
        load_pend_next = 1'b0;
        cache_next     = head_ent;
        out_valid_next = out_valid_reg && !result.ready;
        out_rank_next  = out_rank_reg;
        out_ovf_next   = out_ovf_reg;
        cnt_idx        = head_ent.term;
        cnt_wval       = cnt_rd;
        cnt_we         = 1'b0;
        cnt_clr        = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = head_reg + fill_reg[PTR_W-1:0];
        ram_wdata      = '{pos: pos_reg, term: term_reg};
        ram_raddr      = head_reg + PTR_W'(1);
        rctl           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    scored_next = 1'b0;
                    state_next  = ST_FIT;
                end
            end

            ST_FIT:
            begin
                if (!present_reg)
                begin
                    state_next = last_reg ? ST_FINAL : ST_IDLE;
                end
                else if (fits)
                begin
                    state_next = full ? ST_OVF : ST_ADD;
                end
                else
                begin
                    // score once per word, then drop the oldest hit
                    if (!scored_reg)
                    begin
                        rctl.score  = 1'b1;
                        scored_next = 1'b1;
                    end
                    cnt_we = 1'b1;
                    if (cnt_rd != '0)
                    begin
                        cnt_wval = cnt_rd - COUNT_W'(1);
                        if ((cnt_rd == COUNT_W'(1)) && (distinct_reg != '0))
                        begin
                            distinct_next = distinct_reg - DISTINCT_W'(1);
                        end
                    end
                    head_next = head_reg + PTR_W'(1);
                    fill_next = fill_reg - FILL_W'(1);
                    if (fill_reg > FILL_W'(1))
                    begin
                        ram_re         = 1'b1;
                        load_pend_next = 1'b1;
                    end
                end
            end

            ST_OVF:
            begin
                // store full: drop oldest unscored, flag overflow
                rctl.set_ovf = 1'b1;
                cnt_we       = 1'b1;
                if (cnt_rd != '0)
                begin
                    cnt_wval = cnt_rd - COUNT_W'(1);
                    if ((cnt_rd == COUNT_W'(1)) && (distinct_reg != '0))
                    begin
                        distinct_next = distinct_reg - DISTINCT_W'(1);
                    end
                end
                head_next      = head_reg + PTR_W'(1);
                fill_next      = fill_reg - FILL_W'(1);
                ram_re         = 1'b1;
                load_pend_next = 1'b1;
                state_next     = ST_ADD;
            end

            ST_ADD:
            begin
                ram_we   = 1'b1;
                cnt_idx  = term_reg;
                cnt_we   = 1'b1;
                cnt_wval = cnt_rd + COUNT_W'(1);
                if (cnt_rd == '0)
                begin
                    distinct_next = distinct_reg + DISTINCT_W'(1);
                end
                fill_next = fill_reg + FILL_W'(1);
                if (fill_reg == '0)
                begin
                    cache_next = '{pos: pos_reg, term: term_reg};
                end
                state_next = last_reg ? ST_FINAL : ST_IDLE;
            end

            ST_FINAL:
            begin
                if (fill_reg != '0)
                begin
                    rctl.score = 1'b1;
                end
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                // wait for the result register, then start a fresh zone
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_rank_next  = rank;
                    out_ovf_next   = rank_ovf;
                    rctl.clear     = 1'b1;
                    cnt_clr        = 1'b1;
                    head_next      = '0;
                    fill_next      = '0;
                    distinct_next  = '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            distinct_reg  <= '0;
            scored_reg    <= 1'b0;
            load_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            distinct_reg  <= distinct_next;
            scored_reg    <= scored_next;
            load_pend_reg <= load_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cache_reg    <= cache_next;
        out_rank_reg <= out_rank_next;
        out_ovf_reg  <= out_ovf_next;
        if (accept)
        begin
            pos_reg     <= hits.position;
            term_reg    <= hits.term_index;
            present_reg <= hits.present;
            last_reg    <= hits.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TERMS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (cnt_clr)
        begin
            for (int i = 0; i < MAX_TERMS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (cnt_we)
        begin
            counts_reg[cnt_idx] <= cnt_wval;
        end
    end

endmodule

/* tb/tpws_rank_checker.sv */
`timescale 1ns / 1ps
// Rank checker for the term proximity window scorer.
// Follows register writes and hit words, predicts each zone's rank word and compares it.
// Depends on tpws_pkg and the channel interfaces of tpws_if.sv.
module tpws_rank_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tpws_pkg::PADDR_W-1:0] paddr,
    input  logic [tpws_pkg::PDATA_W-1:0] pwdata,
    input  logic                         pready,
    tpws_hit_if                          hits,
    tpws_res_if                          result,
    output int                           mismatches,
    output int                           ranks_due,
    output int                           ranks_checked,
    output int                           overflow_ranks
);
    import tpws_pkg::*;

    localparam longint unsigned   PARTIAL_Q8 = 51200;
    localparam logic [RANK_W-1:0] RANK_CEIL  = '1;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              overflow;
    } zone_rank_t;

    // own copy of the window state
    logic [POS_W-1:0]  ring_pos  [WINDOW_DEPTH];
    logic [TERM_W-1:0] ring_term [WINDOW_DEPTH];
    logic [PTR_W-1:0]  oldest_slot;
    int unsigned       held;
    int unsigned       term_hits [MAX_TERMS];
    int unsigned       distinct;
    logic [RANK_W-1:0] zone_rank;
    logic              zone_ovf;
    logic [WS_W-1:0]   size_reg;
    zone_rank_t        rank_queue [$];

    function automatic int unsigned span_limit();
        int unsigned w;
        w = size_reg;
        if (w == 0)
        begin
            w = 1;
        end
        if (w > MAX_WINDOW)
        begin
            w = MAX_WINDOW;
        end
        return w;
    endfunction

    function automatic void clear_zone();
        foreach (term_hits[i])
        begin
            term_hits[i] = 0;
        end
        oldest_slot = '0;
        held        = 0;
        distinct    = 0;
        zone_rank   = '0;
        zone_ovf    = 1'b0;
    endfunction

    function automatic void score_window();
        longint unsigned bonus;
        if (distinct >= span_limit())
        begin
            bonus = FULL_BONUS;
        end
        else
        begin
            bonus = (PARTIAL_Q8 * distinct) / span_limit();
        end
        if (64'(zone_rank) > 64'(RANK_CEIL) - bonus)
        begin
            zone_rank = RANK_CEIL;
            zone_ovf  = 1'b1;
        end
        else
        begin
            zone_rank = zone_rank + RANK_W'(bonus);
        end
    endfunction

    function automatic void drop_oldest();
        int unsigned t;
        if (held == 0)
        begin
            return;
        end
        t = ring_term[oldest_slot] % MAX_TERMS;
        if (term_hits[t] > 0)
        begin
            term_hits[t]--;
            if (term_hits[t] == 0 && distinct > 0)
            begin
                distinct--;
            end
        end
        oldest_slot = oldest_slot + 1'b1;   // wraps at the ring depth
        held--;
    endfunction

    function automatic bit hit_fits(input logic [POS_W-1:0] pos);
        int unsigned oldest;
        if (held == 0)
        begin
            return 1'b1;
        end
        oldest = ring_pos[oldest_slot];
        return (pos >= oldest) && ((pos - oldest) < span_limit());
    endfunction

    function automatic void add_hit(input logic [POS_W-1:0] pos, input logic [TERM_W-1:0] term);
        logic [PTR_W-1:0] slot;
        int unsigned      t;
        t = term % MAX_TERMS;
        if (held >= WINDOW_DEPTH)
        begin
            drop_oldest();
            zone_ovf = 1'b1;
        end
        slot            = oldest_slot + PTR_W'(held);
        ring_pos[slot]  = pos;
        ring_term[slot] = term;
        held++;
        if (term_hits[t] == 0)
        begin
            distinct++;
        end
        term_hits[t]++;
    endfunction

    function automatic void take_word(
        input logic [POS_W-1:0]  pos,
        input logic [TERM_W-1:0] term,
        input logic              present,
        input logic              last
    );
        zone_rank_t due;
        if (present)
        begin
            if (!hit_fits(pos))
            begin
                score_window();
                drop_oldest();
                while (!hit_fits(pos))
                begin
                    drop_oldest();
                end
            end
            add_hit(pos, term);
        end
        if (last)
        begin
            if (held > 0)
            begin
                score_window();
            end
            due.rank     = zone_rank;
            due.overflow = zone_ovf;
            rank_queue.insert(rank_queue.size(), due);
            if (zone_ovf)
            begin
                overflow_ranks++;
            end
            clear_zone();
        end
    endfunction

    task automatic report_mismatch(
        input string             what,
        input logic [RANK_W-1:0] got,
        input logic [RANK_W-1:0] want
    );
        mismatches++;
        $display("[%0t] rank check: %s got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_rank();
        zone_rank_t want;
        if (rank_queue.size() == 0)
        begin
            report_mismatch("rank word with no zone pending", result.rank, '0);
            return;
        end
        want = rank_queue.pop_front();
        ranks_checked++;
        if (result.rank !== want.rank)
        begin
            report_mismatch("rank", result.rank, want.rank);
        end
        if (result.overflow !== want.overflow)
        begin
            report_mismatch("overflow", RANK_W'(result.overflow), RANK_W'(want.overflow));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg = WS_W'(WS_RESET);
            clear_zone();
            rank_queue.delete();
            mismatches     = 0;
            ranks_checked  = 0;
            overflow_ranks = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == {REG_WINDOW_SIZE, 2'b00})
            begin
                size_reg = pwdata[WS_W-1:0];
            end
            if (hits.valid && hits.ready)
            begin
                take_word(hits.position, hits.term_index, hits.present, hits.last);
            end
            if (result.valid && result.ready)
            begin
                check_rank();
            end
        end
        ranks_due = rank_queue.size();
    end

endmodule

/* tb/term_proximity_window_scorer_core_tb.sv */
`timescale 1ns / 1ps
// Top of the term proximity window scorer testbench: clock, reset, register writes,
// hit word stimulus, output stalls and verdict. Depends on tpws_pkg, tpws_if.sv,
// tpws_rank_checker and the scorer core.
module term_proximity_window_scorer_core_tb;
    import tpws_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;  // generous over the slowest legal run
    localparam int DRAIN_CYCLES = 40;      // fit check + a full ring of drops + final score
    localparam int HOLD_CYCLES  = 400;     // the one long output stall
    localparam int PHASE_WORDS  = 100;
    localparam int N_PHASES     = 7;

    // window size per random phase: max, zero, clamped, small, odd, one, mid
    localparam logic [WS_W-1:0] PHASE_SIZE [N_PHASES] = '{10, 0, 15, 2, 7, 1, 5};

    typedef enum int {
        ZONE_CLEAN,     // ascending hits, terms mostly inside the query
        ZONE_NOISY,     // random positions, terms and present bits
        ZONE_EMPTY,     // a bare last marker
        ZONE_CROWDED    // more hits than the ring holds, in one span
    } zone_kind_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tpws_hit_if hit_ch ();
    tpws_res_if res_ch ();

    int mismatches;
    int ranks_due;
    int ranks_checked;
    int overflow_ranks;

    int          words_sent;
    int          zones_sent;
    int          cycle_count;
    int unsigned cur_size;
    bit          hold_request;
    bit          sink_steady;
    bit          no_gaps;

    term_proximity_window_scorer_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .hits    (hit_ch),
        .result  (res_ch)
    );

    tpws_rank_checker rank_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .hits           (hit_ch),
        .result         (res_ch),
        .mismatches     (mismatches),
        .ranks_due      (ranks_due),
        .ranks_checked  (ranks_checked),
        .overflow_ranks (overflow_ranks)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a stuck handshake or a rank word that never comes ends here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d rank words still due", cycle_count, ranks_due);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side. Mostly ready in short bursts, short and the odd long stall;
    // a hold request from the stimulus gives one long stretch held off, so the
    // core parks a rank word in its output register and stops taking hit words.
    initial
    begin
        int unsigned r;
        int unsigned dur;
        logic        lvl;
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                lvl          = 1'b0;
                dur          = HOLD_CYCLES;
            end
            else if (sink_steady)
            begin
                lvl = 1'b1;
                dur = 1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    lvl = 1'b1;
                    dur = $urandom_range(1, 8);
                end
                else if (r < 95)
                begin
                    lvl = 1'b0;
                    dur = $urandom_range(1, 3);
                end
                else
                begin
                    lvl = 1'b0;
                    dur = $urandom_range(10, 40);
                end
            end
            res_ch.ready <= lvl;
            repeat (dur) @(posedge clk);
        end
    end

    // Gap before a hit word: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic zone_kind_t pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 72)
        begin
            return ZONE_CLEAN;
        end
        if (r < 86)
        begin
            return ZONE_NOISY;
        end
        if (r < 94)
        begin
            return ZONE_EMPTY;
        end
        return ZONE_CROWDED;
    endfunction

    // Offers one hit word and returns in the step of its acceptance. valid is
    // left high so back-to-back words need no second assignment in one step.
    task automatic send_word(
        input logic [POS_W-1:0]  pos,
        input logic [TERM_W-1:0] term,
        input logic              present,
        input logic              last
    );
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            hit_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hit_ch.valid      <= 1'b1;
        hit_ch.position   <= pos;
        hit_ch.term_index <= term;
        hit_ch.present    <= present;
        hit_ch.last       <= last;
        @(posedge clk iff hit_ch.ready);
        words_sent++;
    endtask

    // Drops valid and waits until every rank word has come back, then lets the
    // core settle for its longest internal run.
    task automatic wait_idle();
        hit_ch.valid <= 1'b0;
        @(posedge clk);
        while (ranks_due != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_window_size(input logic [WS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_WINDOW_SIZE, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk iff pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_size = value;
    endtask

    // One zone of hit words, ending in a word with last set: either on the
    // final hit or on a separate empty marker.
    task automatic send_zone(input zone_kind_t kind);
        int unsigned       n;
        int unsigned       span;
        int unsigned       i;
        logic [POS_W-1:0]  p;
        logic [TERM_W-1:0] t;
        bit                marker_end;
        bit                fin;
        span = (cur_size == 0) ? 1 : ((cur_size > MAX_WINDOW) ? MAX_WINDOW : cur_size);
        // now and then start near the top so positions wrap below the oldest hit
        if ($urandom_range(0, 7) == 0)
        begin
            p = POS_W'($urandom_range(65500, 65535));
        end
        else
        begin
            p = POS_W'($urandom);
        end
        marker_end = 1'($urandom_range(0, 1));
        unique case (kind)
            ZONE_EMPTY:   n = 0;
            ZONE_CROWDED: n = $urandom_range(33, 44);
            default:      n = $urandom_range(1, 12);
        endcase
        for (i = 0; i < n; i++)
        begin
            fin = (i == n - 1) && !marker_end;
            unique case (kind)
                ZONE_NOISY:
                begin
                    send_word(POS_W'($urandom), TERM_W'($urandom),
                              1'($urandom_range(0, 1)), fin);
                end
                ZONE_CROWDED:
                begin
                    // same position mostly, so the ring fills within one span
                    if ($urandom_range(0, 9) == 0)
                    begin
                        p = p + 1'b1;
                    end
                    send_word(p, TERM_W'($urandom), 1'b1, fin);
                end
                default:
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_word(POS_W'($urandom), TERM_W'($urandom), 1'b0, 1'b0);
                    end
                    if ($urandom_range(0, 19) == 0)
                    begin
                        p = p - POS_W'($urandom_range(1, 20));
                    end
                    else
                    begin
                        p = p + POS_W'($urandom_range(0, span + 1));
                    end
                    if ($urandom_range(0, 4) == 0)
                    begin
                        t = TERM_W'($urandom);
                    end
                    else
                    begin
                        t = TERM_W'($urandom_range(0, span - 1));
                    end
                    send_word(p, t, 1'b1, fin);
                end
            endcase
        end
        if (marker_end || n == 0)
        begin
            send_word(POS_W'($urandom), TERM_W'($urandom), 1'b0, 1'b1);
        end
        zones_sent++;
    endtask

    initial
    begin
        int  ph;
        int  phase_start;
        bit  paused;

        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        hit_ch.valid      = 1'b0;
        hit_ch.position   = '0;
        hit_ch.term_index = '0;
        hit_ch.present    = 1'b0;
        hit_ch.last       = 1'b0;
        hold_request      = 1'b0;
        sink_steady       = 1'b0;
        no_gaps           = 1'b0;
        words_sent        = 0;
        zones_sent        = 0;
        cur_size          = WS_RESET;
        paused            = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, window size left at its reset value of one.
        // Empty zone: rank zero.
        send_word(16'h0000, 4'h0, 1'b0, 1'b1);
        // Single hit at the top position and term, carrying last: one full bonus.
        send_word(16'hFFFF, 4'hF, 1'b1, 1'b1);
        wait_idle();

        // Size three: a full window, an ignored empty word, a hit past the span
        // (scores, drops one), a hit below the oldest (scores, empties the
        // window), then a bare last marker scoring the partial window.
        write_window_size(4'd3);
        send_word(16'd100, 4'd0, 1'b1, 1'b0);
        send_word(16'd101, 4'd1, 1'b1, 1'b0);
        send_word(16'd102, 4'd2, 1'b1, 1'b0);
        send_word(16'h00AB, 4'hA, 1'b0, 1'b0);
        send_word(16'd103, 4'd5, 1'b1, 1'b0);
        send_word(16'd40, 4'd3, 1'b1, 1'b0);
        send_word(16'h5555, 4'h9, 1'b0, 1'b1);
        wait_idle();

        // Size ten, the largest: ten terms in ten positions, last on the tenth.
        write_window_size(4'd10);
        for (int i = 0; i < 10; i++)
        begin
            send_word(POS_W'(1000 + i), TERM_W'(i), 1'b1, i == 9);
        end
        wait_idle();

        // Random phases, one window size each, register written while idle.
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            write_window_size(PHASE_SIZE[ph]);
            no_gaps     = (ph == 5);
            sink_steady = (ph == 5);
            if (ph == 2)
            begin
                hold_request = 1'b1;    // long output stall while words keep coming
            end
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                // halfway through one phase the sender drains everything first
                if (ph == 4 && !paused && words_sent - phase_start >= PHASE_WORDS / 2)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
                send_zone(pick_kind());
            end
            wait_idle();
        end

        $display("Run covered %0d hit words in %0d zones, window sizes 0 to 15 incl. clamping,",
                 words_sent, zones_sent);
        $display("%0d rank words checked, %0d with overflow, one long stall and one full drain.",
                 ranks_checked, overflow_ranks);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/tpws_pkg.sv
rtl/core/tpws_if.sv
rtl/core/tpws_ram.sv
rtl/core/tpws_cfg.sv
rtl/core/tpws_rank.sv
rtl/core/term_proximity_window_scorer_core.sv
tb/tpws_rank_checker.sv
tb/term_proximity_window_scorer_core_tb.sv
